// ===== src/tmap_pkg.sv =====
package tmap_pkg;

  // Width of one sample and of one mapped level.
  localparam int SAMPLE_BITS = 32;
  localparam int LEVEL_BITS  = 8;

  // Number of quotient bits the divider produces, one per cycle.
  localparam int QUO_STEPS = LEVEL_BITS;
  localparam int STEP_BITS = (QUO_STEPS > 1) ? $clog2(QUO_STEPS) : 1;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = '0;

  // Pass codes carried in the op field.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_BITS-1:0]  level_t;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_PREP,
    DIV_ITER,
    DIV_FIX,
    DIV_DONE
  } div_state_t;

  // Requests from the top level to the divider.
  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  // Status from the divider to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Offset-binary key: unsigned order of keys equals signed order of samples.
  function automatic sample_t order_key(input sample_t value);
    order_key = value ^ SIGN_MASK;
  endfunction

endpackage

// ===== src/tmap_if.sv =====
// Sample channel into the tone mapper.
interface tmap_in_if;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic                  first;
  tmap_pkg::sample_t     sample;

  modport source (output valid, output op, output first, output sample, input ready);
  modport sink   (input valid, input op, input first, input sample, output ready);
endinterface

// Level channel out of the tone mapper.
interface tmap_out_if;
  logic                  valid;
  logic                  ready;
  tmap_pkg::level_t      level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ===== src/tmap_marks.sv =====
// Running minimum and maximum of the measure pass.
module tmap_marks (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  logic              first,
  input  tmap_pkg::sample_t sample,
  output tmap_pkg::sample_t lo_key,
  output tmap_pkg::sample_t hi_key
);
  import tmap_pkg::*;

  sample_t low_mark;
  sample_t high_mark;
  sample_t sample_key;

  assign sample_key = order_key(sample);
  assign lo_key     = order_key(low_mark);
  assign hi_key     = order_key(high_mark);

  // A first sample restarts both marks; any other sample only widens them.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_mark  <= '0;
      high_mark <= '0;
    end else if (update) begin
      if (first) begin
        low_mark  <= sample;
        high_mark <= sample;
      end else begin
        if (sample_key > hi_key) begin
          high_mark <= sample;
        end
        if (sample_key < lo_key) begin
          low_mark <= sample;
        end
      end
    end
  end

endmodule

// ===== src/tmap_div.sv =====
// Bit-serial scaler: one quotient bit of floor(256*num/den) per cycle,
// then a one-step correction to floor(255*num/den).
module tmap_div (
  input  logic                clk,
  input  logic                rst,
  input  tmap_pkg::div_ctrl_t ctrl,
  input  tmap_pkg::sample_t   sample_key,
  input  tmap_pkg::sample_t   lo_key,
  input  tmap_pkg::sample_t   hi_key,
  output tmap_pkg::div_stat_t stat,
  output tmap_pkg::level_t    level
);
  import tmap_pkg::*;

  div_state_t             state;
  div_state_t             state_next;
  sample_t                key;
  sample_t                num;
  sample_t                den;
  sample_t                rem;
  level_t                 acc;
  logic [STEP_BITS-1:0]   step;
  logic                   flat;
  logic                   below;
  logic                   above;
  logic [SAMPLE_BITS+1:0] trial;
  logic                   trial_neg;

  // Saturation cases, checked once the sample key is held.
  assign flat  = (hi_key <= lo_key);
  assign below = (key <= lo_key);
  assign above = (key >= hi_key);

  // One restoring step: does twice the remainder reach the divisor?
  assign trial     = {1'b0, rem, 1'b0} - {2'b00, den};
  assign trial_neg = trial[SAMPLE_BITS+1];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: begin
        if (ctrl.start) begin
          state_next = DIV_PREP;
        end
      end
      DIV_PREP: begin
        if (flat || below || above) begin
          state_next = DIV_DONE;
        end else begin
          state_next = DIV_ITER;
        end
      end
      DIV_ITER: begin
        if (step == STEP_BITS'(QUO_STEPS - 1)) begin
          state_next = DIV_FIX;
        end
      end
      DIV_FIX: begin
        state_next = DIV_DONE;
      end
      DIV_DONE: begin
        if (ctrl.take) begin
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  // Status outputs.
  always_comb begin
    stat.busy = 1'b1;
    stat.done = 1'b0;
    unique case (state)
      DIV_IDLE: begin
        stat.busy = 1'b0;
      end
      DIV_DONE: begin
        stat.done = 1'b1;
      end
      default: begin
        stat.busy = 1'b1;
      end
    endcase
  end

  assign level = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: quotient bits shift into acc one per cycle.
  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        key  <= sample_key;
        step <= '0;
      end
      DIV_PREP: begin
        num  <= key - lo_key;
        rem  <= key - lo_key;
        den  <= hi_key - lo_key;
        step <= '0;
        if (flat || below) begin
          acc <= LEVEL_MIN;
        end else if (above) begin
          acc <= LEVEL_MAX;
        end else begin
          acc <= '0;
        end
      end
      DIV_ITER: begin
        step <= step + STEP_BITS'(1);
        if (!trial_neg) begin
          rem <= trial[SAMPLE_BITS-1:0];
          acc <= {acc[LEVEL_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[SAMPLE_BITS-2:0], 1'b0};
          acc <= {acc[LEVEL_BITS-2:0], 1'b0};
        end
      end
      DIV_FIX: begin
        // 255*num = acc*den + rem - num, so a short remainder costs one level.
        if (rem < num) begin
          acc <= acc - LEVEL_BITS'(1);
        end
      end
      DIV_DONE: begin
        step <= '0;
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== src/minmax_linear_tone_map.sv =====
// Channel   Role    Transaction payload
// samples   sink    op (0 measure, 1 map), first, sample (signed Q16.16)
// levels    source  level (8-bit mapped component)
//
// A measure sample updates the running min/max marks.
// A map sample that is divided goes through load, set-up, eight quotient bits
// in the serial divider, correction and hand-off; a saturating one skips to hand-off.
// The divider handles one map sample at a time; samples wait while it is busy.
// A result waiting in the output register does not hold back the next sample.
// Synchronous reset clears the marks to zero and empties both channels.
module minmax_linear_tone_map (
  input logic       clk,
  input logic       rst,
  tmap_in_if.sink   samples,
  tmap_out_if.source levels
);
  import tmap_pkg::*;

  logic      in_accept;
  logic      measure_accept;
  logic      map_accept;
  logic      load;
  logic      out_valid;
  level_t    out_level;
  level_t    div_level;
  sample_t   lo_key;
  sample_t   hi_key;
  sample_t   sample_key;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  // Input handshake: new samples only while the divider is free.
  assign samples.ready  = !div_stat.busy;
  assign in_accept      = samples.valid && samples.ready;
  assign measure_accept = in_accept && (samples.op == OP_MEASURE);
  assign map_accept     = in_accept && (samples.op == OP_MAP);
  assign sample_key     = order_key(samples.sample);

  tmap_marks u_marks (
    .clk    (clk),
    .rst    (rst),
    .update (measure_accept),
    .first  (samples.first),
    .sample (samples.sample),
    .lo_key (lo_key),
    .hi_key (hi_key)
  );

  // Hand the result over as soon as the output register is free.
  assign load          = div_stat.done && (!out_valid || levels.ready);
  assign div_ctrl.start = map_accept;
  assign div_ctrl.take  = load;

  tmap_div u_div (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (div_ctrl),
    .sample_key (sample_key),
    .lo_key     (lo_key),
    .hi_key     (hi_key),
    .stat       (div_stat),
    .level      (div_level)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_level <= div_level;
    end
  end

  assign levels.valid = out_valid;
  assign levels.level = out_level;

`ifndef SYNTHESIS
  // The marks never cross: the minimum stays at or below the maximum.
  a_marks_ordered: assert property (@(posedge clk) disable iff (rst)
    lo_key <= hi_key)
    else $error("minimum mark above maximum mark");

  // A map sample always starts the divider.
  a_map_starts_div: assert property (@(posedge clk) disable iff (rst)
    map_accept |=> div_stat.busy)
    else $error("map transaction did not start the divider");

  // A finished quotient that is handed over shows up on the output.
  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && !div_stat.busy))
    else $error("divider result lost on hand-off");

  // Measure samples never produce a result on their own.
  a_measure_silent: assert property (@(posedge clk) disable iff (rst)
    (measure_accept && !div_stat.busy && !out_valid) |=> !out_valid)
    else $error("measure transaction produced a level");
`endif

endmodule

// ===== test/minmax_linear_tone_map_checker.sv =====
// Watches both channels of the tone mapper. It keeps its own running marks,
// predicts one level per map transaction and compares the levels in order.
module minmax_linear_tone_map_checker (
  input  logic clk,
  input  logic rst,
  tmap_in_if   samples,
  tmap_out_if  levels,
  input  logic closing,
  output int   errors,
  output int   pending,
  output int   frames,
  output int   measures,
  output int   maps,
  output int   compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmap_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] mark_t;

  // Running marks as the block should hold them.
  mark_t  run_min;
  mark_t  run_max;
  level_t levels_due[$];

  initial begin
    errors   = 0;
    pending  = 0;
    frames   = 0;
    measures = 0;
    maps     = 0;
    compared = 0;
    run_min  = '0;
    run_max  = '0;
  end

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] level check: %s", $time, msg);
  endtask

  // Level for one map sample against the current marks, done in 64-bit math.
  function automatic level_t map_level(input mark_t value, input mark_t lo, input mark_t hi);
    longint v;
    longint l;
    longint h;
    v = longint'(value);
    l = longint'(lo);
    h = longint'(hi);
    // A flat frame has no range, so every sample maps to the bottom level.
    if (h <= l) return LEVEL_MIN;
    if (v <= l) return LEVEL_MIN;
    if (v >= h) return LEVEL_MAX;
    return level_t'(((v - l) * longint'(LEVEL_MAX)) / (h - l));
  endfunction

  // Levels are checked before the same edge's sample is taken into the marks.
  always @(posedge clk) begin : track
    level_t want;
    mark_t  incoming;
    if (rst) begin
      run_min = '0;
      run_max = '0;
      levels_due.delete();
    end else begin
      if (levels.valid && levels.ready) begin
        if (levels_due.size() == 0) begin
          report_mismatch($sformatf("level %0d arrived with none expected", levels.level));
        end else begin
          want = levels_due.pop_front();
          compared++;
          if (levels.level !== want) begin
            report_mismatch($sformatf("level %0d, expected %0d", levels.level, want));
          end
        end
      end
      if (samples.valid && samples.ready) begin
        incoming = mark_t'(samples.sample);
        if (samples.op == OP_MEASURE) begin
          measures++;
          // A first sample restarts both marks; otherwise they only widen.
          if (samples.first) begin
            frames++;
            run_min = incoming;
            run_max = incoming;
          end else begin
            if (incoming > run_max) run_max = incoming;
            if (incoming < run_min) run_min = incoming;
          end
        end else begin
          maps++;
          levels_due.push_back(map_level(incoming, run_min, run_max));
        end
      end
    end
    pending = levels_due.size();
  end

  // At the close of the run any level still due is a failure.
  always @(posedge closing) begin
    if (levels_due.size() != 0) begin
      report_mismatch($sformatf("%0d levels never arrived, oldest expected %0d",
                                levels_due.size(), levels_due[0]));
    end
  end

endmodule

// ===== test/minmax_linear_tone_map_tb.sv =====
module minmax_linear_tone_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmap_pkg::*;

  localparam int ITEM_TARGET = 1975;

  // Kinds of frame content.
  localparam int STYLE_WIDE   = 0;
  localparam int STYLE_NARROW = 1;
  localparam int STYLE_FLAT   = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic closing = 1'b0;

  int errors;
  int pending;
  int frames;
  int measures;
  int maps;
  int compared;

  // Stimulus bookkeeping: marks as the sender sees them, for aiming map samples.
  longint frame_lo = 0;
  longint frame_hi = 0;
  int     sent = 0;
  bit     burst = 1'b0;

  tmap_in_if  samples ();
  tmap_out_if levels ();

  minmax_linear_tone_map u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .levels  (levels)
  );

  minmax_linear_tone_map_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .levels   (levels),
    .closing  (closing),
    .errors   (errors),
    .pending  (pending),
    .frames   (frames),
    .measures (measures),
    .maps     (maps),
    .compared (compared)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones; none during a burst.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // One sample for the measure pass of a frame of the given kind.
  function automatic sample_t frame_sample(input int style, input sample_t base,
                                           input int unsigned spread);
    int r;
    r = $urandom_range(0, 15);
    case (style)
      STYLE_FLAT: return base;
      STYLE_WIDE: begin
        if (r == 0) return SIGN_MASK;
        if (r == 1) return ~SIGN_MASK;
        if (r == 2) return '1;
        if (r == 3) return '0;
        return sample_t'($urandom);
      end
      default: return base + sample_t'($urandom_range(0, spread));
    endcase
  endfunction

  // One sample for the map pass: mostly inside the measured range.
  function automatic sample_t map_pick();
    int r;
    longint unsigned raw;
    longint span;
    r = $urandom_range(0, 99);
    span = frame_hi - frame_lo + 1;
    raw = {$urandom, $urandom};
    if (r < 70) return sample_t'(frame_lo + longint'(raw % $unsigned(span)));
    if (r < 80) return sample_t'(frame_lo);
    if (r < 88) return sample_t'(frame_hi);
    if (r < 91) return sample_t'(frame_lo - 1);
    if (r < 94) return sample_t'(frame_hi + 1);
    return sample_t'($urandom);
  endfunction

  // Drives one transaction after an idle gap and waits until it is taken.
  task automatic push_sample(input logic op, input logic first_flag, input sample_t value,
                             input int gap);
    longint v;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.op     <= op;
    samples.first  <= first_flag;
    samples.sample <= value;
    samples.valid  <= 1'b1;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    // Follow the marks so later map samples can be aimed at the range.
    if (op == OP_MEASURE) begin
      v = longint'($signed(value));
      if (first_flag) begin
        frame_lo = v;
        frame_hi = v;
      end else begin
        if (v > frame_hi) frame_hi = v;
        if (v < frame_lo) frame_lo = v;
      end
    end
  endtask

  // Level acceptor: runs of ready, broken by stalls of mixed length.
  initial begin : level_sink
    int hold;
    int stall;
    int r;
    levels.ready = 1'b0;
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      hold = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      r = $urandom_range(0, 99);
      if (r < 30) stall = 0;
      else if (r < 80) stall = $urandom_range(1, 3);
      else stall = $urandom_range(10, 40);
      levels.ready <= 1'b1;
      repeat (hold) @(negedge clk);
      if (stall > 0) begin
        levels.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int          style;
    int          n_meas;
    int          n_map;
    int          wait_cycles;
    int unsigned spread;
    sample_t     base;
    bit          broken;
    samples.valid  = 1'b0;
    samples.op     = OP_MEASURE;
    samples.first  = 1'b0;
    samples.sample = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Map right after reset: the marks are both zero, so the frame is flat.
    push_sample(OP_MAP, 1'b0, '0, pick_gap());
    push_sample(OP_MAP, 1'b0, SIGN_MASK, pick_gap());
    // Measure with no first yet widens from the reset marks.
    push_sample(OP_MEASURE, 1'b0, sample_t'(100), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(50), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(100), pick_gap());
    push_sample(OP_MAP, 1'b0, '0, pick_gap());
    push_sample(OP_MAP, 1'b0, '1, pick_gap());
    push_sample(OP_MAP, 1'b0, ~SIGN_MASK, pick_gap());
    // Full-scale frame: both extremes of the sample field.
    push_sample(OP_MEASURE, 1'b1, ~SIGN_MASK, pick_gap());
    push_sample(OP_MEASURE, 1'b0, SIGN_MASK, pick_gap());
    push_sample(OP_MAP, 1'b0, '0, pick_gap());
    push_sample(OP_MAP, 1'b0, '1, pick_gap());
    push_sample(OP_MAP, 1'b0, ~SIGN_MASK - 1, pick_gap());
    push_sample(OP_MAP, 1'b0, SIGN_MASK + 1, pick_gap());
    push_sample(OP_MAP, 1'b0, SIGN_MASK, pick_gap());
    push_sample(OP_MAP, 1'b0, ~SIGN_MASK, pick_gap());
    // The first flag on a map transaction must leave the marks alone.
    push_sample(OP_MAP, 1'b1, sample_t'(5), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(5), pick_gap());
    // Flat frame: every level is zero, even outside the single value.
    push_sample(OP_MEASURE, 1'b1, sample_t'(42), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(42), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(43), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(41), pick_gap());
    // Small range that straddles zero.
    push_sample(OP_MEASURE, 1'b1, sample_t'(-10), pick_gap());
    push_sample(OP_MEASURE, 1'b0, sample_t'(10), pick_gap());
    push_sample(OP_MAP, 1'b0, sample_t'(9), pick_gap());

    // Random frames: a measure pass then a map pass, with some noise mixed in.
    while (sent < ITEM_TARGET) begin
      burst  = ($urandom_range(0, 3) == 0);
      style  = $urandom_range(0, 3);
      if (style > STYLE_FLAT) style = STYLE_NARROW;
      base   = sample_t'($urandom);
      spread = $urandom_range(0, 32'd1 << $urandom_range(0, 24));
      broken = ($urandom_range(0, 9) == 0);
      n_meas = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      n_map  = $urandom_range(1, 16);
      for (int k = 0; k < n_meas; k++) begin
        push_sample(OP_MEASURE,
                    ((k == 0) && !broken) || ($urandom_range(0, 39) == 0),
                    frame_sample(style, base, spread), pick_gap());
      end
      for (int k = 0; k < n_map; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          push_sample(OP_MEASURE, 1'b0, frame_sample(style, base, spread), pick_gap());
        end
        push_sample(OP_MAP, ($urandom_range(0, 9) == 0), map_pick(), pick_gap());
      end
    end
    samples.valid <= 1'b0;

    // Drain: wait for the last levels, then allow for stray ones.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    closing <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Covered %0d frames: %0d measure and %0d map transactions.",
             frames, measures, maps);
    $display("Compared %0d levels with %0d mismatches.", compared, errors);
    if (errors == 0) begin
      $display("minmax_linear_tone_map regression: pass");
    end else begin
      $display("minmax_linear_tone_map regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #15_000_000;
    $display("minmax_linear_tone_map regression: fail");
    $finish;
  end

endmodule
